/* hw/rtl/bsba_pkg.sv */
// Shared types, constants and helper functions for the bitmap slot/block allocator.
// Depends on nothing; every file in hw/rtl but bsba_ram imports it.
package bsba_pkg;

    localparam int DEF_SLOTS       = 32768;
    localparam int DEF_BLOCK_SLOTS = 64;
    localparam int WORD_BITS       = 64;
    localparam int WIN_BITS        = 2 * WORD_BITS;
    localparam int INDEX_W         = 15;
    localparam int OP_W            = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WIN_BITS-1:0]  win_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_SLOT  = 2'd0,
        OP_ALLOC_BLOCK = 2'd1,
        OP_FREE        = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_BLK_ROW,
        ST_BLK_SUM,
        ST_BLK_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MODE_SLOT,
        MODE_SET,
        MODE_CLR
    } rmw_mode_t;

    // Result of checking one map word for a free aligned block that ends in it.
    typedef struct packed {
        logic       hit;
        logic [5:0] end_bit;
        word_t      lo_mask;
        word_t      hi_mask;
    } blk_hit_t;

    // Position of the lowest set bit; zero when no bit is set.
    function automatic logic [5:0] lowest_set(input word_t v);
        logic [5:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

    // Bits at or above nbits are set.
    function automatic word_t pad_mask(input int nbits);
        word_t m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            m[i] = (i >= nbits);
        end
        return m;
    endfunction

    // The lowest n bits are set.
    function automatic win_t low_ones_win(input int n);
        win_t m;
        m = '0;
        for (int i = 0; i < WIN_BITS; i++)
        begin
            m[i] = (i < n);
        end
        return m;
    endfunction

    // Bit j is set when position j is the last slot of an aligned group of bs slots.
    function automatic win_t end_pattern(input int bs);
        win_t e;
        int   k;
        e = '0;
        k = 0;
        for (int j = 0; j < WIN_BITS; j++)
        begin
            k = k + 1;
            if (k == bs)
            begin
                e[j] = 1'b1;
                k    = 0;
            end
        end
        return e;
    endfunction

endpackage

/* hw/rtl/bsba_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the slot map and for the word summary.
module bsba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/bsba_blk_win.sv */
// Finds the lowest free aligned block that ends in the current map word.
// Depends on bsba_pkg; looks at the current word and the word before it.
module bsba_blk_win
    import bsba_pkg::*;
#(
    parameter int BLOCK_SLOTS = DEF_BLOCK_SLOTS
) (
    input  word_t      cur,
    input  word_t      prev,
    input  logic [5:0] phase,
    output blk_hit_t   result
);

    localparam win_t END_PAT  = end_pattern(BLOCK_SLOTS);
    localparam win_t BLK_ONES = low_ones_win(BLOCK_SLOTS);
    localparam int   SH_BASE  = WORD_BITS + 1 - BLOCK_SLOTS;

    win_t       win;
    win_t       win_mask;
    word_t      free_end;
    word_t      end_mask;
    word_t      hit_vec;
    logic [5:0] end_bit;
    logic [6:0] shift;

    assign win = {cur, prev};

    // A block ending at bit p of the current word covers bits p-BLOCK_SLOTS+1 to p.
    always_comb
    begin
        for (int p = 0; p < WORD_BITS; p++)
        begin
            free_end[p] = (win[p + SH_BASE +: BLOCK_SLOTS] == '0);
        end
    end

    // The phase is the slot number of bit 0 modulo BLOCK_SLOTS.
    assign end_mask = END_PAT[phase +: WORD_BITS];
    assign hit_vec  = free_end & end_mask;
    assign end_bit  = lowest_set(hit_vec);
    assign shift    = 7'(end_bit) + 7'(SH_BASE);
    assign win_mask = BLK_ONES << shift;

    assign result.hit     = |hit_vec;
    assign result.end_bit = end_bit;
    assign result.lo_mask = win_mask[WIN_BITS-1:WORD_BITS];
    assign result.hi_mask = win_mask[WORD_BITS-1:0];

endmodule

/* hw/rtl/bitmap_slot_block_allocator.sv */
// Top level of the first-fit bitmap slot and block allocator.
// Depends on bsba_pkg, bsba_ram (slot map and word summary) and bsba_blk_win.
//
//   Channel   Direction   Handshake             Beat contents
//   in        into block  in_valid / in_stall   op, slot_index
//   out       from block  out_valid / out_stall index, status
//
// Allocate-slot reads the word summary, then the map word; free reads both together.
// Either then writes the map word and its summary bits back and loads the output
// register. A slot request on a full pool goes straight to loading the output register.
// Allocate-block scans map words one per cycle from the bottom of the pool,
// skipping each summary row whose 64 words are all full, plus a row check and a
// summary read for each row entered and a write-back of one or two map words; the
// cost grows with the position of the first free aligned block.
// Reset needs no clearing pass: a summary row that was never written reads
// as all words empty, and an empty word reads as zero without trusting the map.
// The output register lets the next item be accepted while a result beat
// waits under out_stall; in_stall is high while an item is being worked on.
module bitmap_slot_block_allocator
    import bsba_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int BLOCK_SLOTS = DEF_BLOCK_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [OP_W-1:0]    op,
    input  logic [INDEX_W-1:0] slot_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] index,
    output logic               status
);

    // Pool geometry. Each summary row covers 64 map words.
    localparam int    MAP_WORDS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int    SUM_ROWS       = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int    AW             = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int    RW             = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
    localparam int    SW             = AW + 6;
    localparam int    SUM_W          = 2 * WORD_BITS;
    localparam int    LAST_BITS      = SLOTS - WORD_BITS * (MAP_WORDS - 1);
    localparam int    LAST_ROW_WORDS = MAP_WORDS - WORD_BITS * (SUM_ROWS - 1);
    localparam word_t LAST_PAD       = pad_mask(LAST_BITS);
    localparam word_t LAST_ROW_MASK  = ~pad_mask(LAST_ROW_WORDS);
    localparam int    WORD_STEP      = WORD_BITS % BLOCK_SLOTS;
    localparam int    ROW_STEP       = (WORD_BITS * WORD_BITS) % BLOCK_SLOTS;

    // Control and payload registers.
    state_t             state_reg, state_next;
    rmw_mode_t          mode_reg, mode_next;
    logic [AW-1:0]      word_reg, word_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [RW-1:0]      sum_row_q_reg, sum_row_q_next;
    word_t              mask_reg, mask_next;
    logic               pend_reg, pend_next;
    word_t              pend_mask_reg, pend_mask_next;
    logic [5:0]         phase_reg, phase_next;
    word_t              prev_reg, prev_next;
    word_t              em_reg, em_next;
    logic [SUM_ROWS-1:0] row_free_reg, row_free_next;
    logic [SUM_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic               out_status_reg, out_status_next;

    // Memory ports.
    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    word_t         map_wdata, map_rdata;
    logic          sum_we;
    logic [RW-1:0] sum_waddr, sum_raddr;
    logic [SUM_W-1:0] sum_wdata, sum_rdata;

    // Datapath signals.
    word_t      nf_rd, em_rd;
    logic [RW-1:0] rmw_row;
    logic [5:0] cur_col;
    word_t      cur_pad;
    word_t      rmw_old, rmw_new;
    logic [5:0] slot_bit;
    logic       new_full, new_empty;
    word_t      nf_new, em_new;
    word_t      rmw_row_mask, find_mask;
    logic [5:0] find_col;
    logic [AW-1:0] find_word;
    logic [RW-1:0] row_first;
    word_t      scan_cur;
    blk_hit_t   blk;
    logic [SW-1:0] blk_start;
    logic       in_pool;
    logic       out_free;
    logic       last_word;
    logic       last_row;
    logic [6:0] ph_word_sum, ph_row_sum;
    logic [5:0] ph_word, ph_row;

    bsba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map_ram (
        .clk  (clk),
        .we   (map_we),
        .waddr(map_waddr),
        .wdata(map_wdata),
        .raddr(map_raddr),
        .rdata(map_rdata)
    );

    // Summary row layout: upper half marks empty words, lower half marks
    // words that still have a free slot.
    bsba_ram #(
        .WIDTH(SUM_W),
        .DEPTH(SUM_ROWS)
    ) u_sum_ram (
        .clk  (clk),
        .we   (sum_we),
        .waddr(sum_waddr),
        .wdata(sum_wdata),
        .raddr(sum_raddr),
        .rdata(sum_rdata)
    );

    bsba_blk_win #(
        .BLOCK_SLOTS(BLOCK_SLOTS)
    ) u_blk_win (
        .cur   (scan_cur),
        .prev  (prev_reg),
        .phase (phase_reg),
        .result(blk)
    );

    // A row never written since reset reads as all words empty and not full.
    assign nf_rd = row_valid_reg[sum_row_q_reg] ? sum_rdata[WORD_BITS-1:0] : '1;
    assign em_rd = row_valid_reg[sum_row_q_reg] ? sum_rdata[SUM_W-1:WORD_BITS] : '1;

    assign rmw_row   = RW'(word_reg >> 6);
    assign cur_col   = 6'(word_reg);
    assign last_word = (word_reg == AW'(MAP_WORDS - 1));
    assign last_row  = (row_reg == RW'(SUM_ROWS - 1));
    // Slots past the end of the pool in the last word always count as used.
    assign cur_pad   = last_word ? LAST_PAD : '0;

    // Read-modify-write of one map word and its summary bits.
    assign rmw_old  = em_rd[cur_col] ? '0 : map_rdata;
    assign slot_bit = lowest_set(~(rmw_old | cur_pad));

    always_comb
    begin
        case (mode_reg)
            MODE_SLOT: rmw_new = rmw_old | (word_t'(1) << slot_bit);
            MODE_SET:  rmw_new = rmw_old | mask_reg;
            MODE_CLR:  rmw_new = rmw_old & ~mask_reg;
            default:   rmw_new = rmw_old;
        endcase
    end

    assign new_full  = ((rmw_new | cur_pad) == '1);
    assign new_empty = (rmw_new == '0);

    always_comb
    begin
        nf_new          = nf_rd;
        em_new          = em_rd;
        nf_new[cur_col] = !new_full;
        em_new[cur_col] = new_empty;
    end

    assign rmw_row_mask = (rmw_row == RW'(SUM_ROWS - 1)) ? LAST_ROW_MASK : '1;
    assign find_mask    = last_row ? LAST_ROW_MASK : '1;
    assign find_col     = lowest_set(nf_rd & find_mask);
    assign find_word    = AW'({row_reg, find_col});

    always_comb
    begin
        row_first = '0;
        for (int i = SUM_ROWS - 1; i >= 0; i--)
        begin
            if (row_free_reg[i])
            begin
                row_first = RW'(i);
            end
        end
    end

    // Block scan: the current word as seen through the summary and pool end.
    assign scan_cur  = (em_reg[cur_col] ? '0 : map_rdata) | cur_pad;
    assign blk_start = SW'({word_reg, blk.end_bit}) - SW'(BLOCK_SLOTS - 1);

    assign ph_word_sum = 7'(phase_reg) + 7'(WORD_STEP);
    assign ph_word     = (ph_word_sum >= 7'(BLOCK_SLOTS)) ?
                         6'(ph_word_sum - 7'(BLOCK_SLOTS)) : 6'(ph_word_sum);
    assign ph_row_sum  = 7'(phase_reg) + 7'(ROW_STEP);
    assign ph_row      = (ph_row_sum >= 7'(BLOCK_SLOTS)) ?
                         6'(ph_row_sum - 7'(BLOCK_SLOTS)) : 6'(ph_row_sum);

    assign in_pool  = (17'(slot_index) < 17'(SLOTS));
    assign out_free = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_ALLOC_SLOT:  state_next = (|row_free_reg) ? ST_FIND : ST_DONE;
                        OP_ALLOC_BLOCK: state_next = ST_BLK_ROW;
                        OP_FREE:        state_next = in_pool ? ST_RMW_RD : ST_DONE;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_FIND:   state_next = ST_RMW_WR;
            ST_RMW_RD: state_next = ST_RMW_WR;
            ST_RMW_WR: state_next = pend_reg ? ST_RMW_RD : ST_DONE;
            ST_BLK_ROW:
            begin
                if (row_free_reg[row_reg])
                begin
                    state_next = ST_BLK_SUM;
                end
                else if (last_row)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BLK_SUM: state_next = ST_BLK_SCAN;
            ST_BLK_SCAN:
            begin
                if (blk.hit)
                begin
                    state_next = ST_RMW_RD;
                end
                else if (last_word)
                begin
                    state_next = ST_DONE;
                end
                else if (cur_col == 6'(WORD_BITS - 1))
                begin
                    state_next = ST_BLK_ROW;
                end
            end
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and outputs.
    always_comb
    begin
        mode_next       = mode_reg;
        word_next       = word_reg;
        row_next        = row_reg;
        mask_next       = mask_reg;
        pend_next       = pend_reg;
        pend_mask_next  = pend_mask_reg;
        phase_next      = phase_reg;
        prev_next       = prev_reg;
        em_next         = em_reg;
        row_free_next   = row_free_reg;
        row_valid_next  = row_valid_reg;
        res_index_next  = res_index_reg;
        res_status_next = res_status_reg;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        map_we    = 1'b0;
        map_waddr = word_reg;
        map_wdata = rmw_new;
        map_raddr = word_reg;
        sum_we    = 1'b0;
        sum_waddr = rmw_row;
        sum_wdata = {em_new, nf_new};
        sum_raddr = rmw_row;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Look at the first row with a free slot ahead of time.
                sum_raddr       = row_first;
                row_next        = row_first;
                res_index_next  = '0;
                res_status_next = 1'b0;
                pend_next       = 1'b0;
                if (in_valid)
                begin
                    unique case (op)
                        OP_ALLOC_SLOT:
                        begin
                            mode_next       = MODE_SLOT;
                            res_status_next = !(|row_free_reg);
                        end
                        OP_ALLOC_BLOCK:
                        begin
                            mode_next  = MODE_SET;
                            row_next   = '0;
                            phase_next = '0;
                            prev_next  = '1;
                        end
                        OP_FREE:
                        begin
                            mode_next      = MODE_CLR;
                            res_index_next = slot_index;
                            word_next      = AW'(slot_index >> 6);
                            mask_next      = word_t'(1) << slot_index[5:0];
                        end
                        default:
                        begin
                            res_index_next = '0;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                map_raddr = find_word;
                sum_raddr = row_reg;
                word_next = find_word;
            end
            ST_RMW_RD:
            begin
                map_raddr = word_reg;
                sum_raddr = rmw_row;
            end
            ST_RMW_WR:
            begin
                map_we                  = 1'b1;
                sum_we                  = 1'b1;
                row_valid_next[rmw_row] = 1'b1;
                row_free_next[rmw_row]  = |(nf_new & rmw_row_mask);
                if (mode_reg == MODE_SLOT)
                begin
                    res_index_next = INDEX_W'({word_reg, slot_bit});
                end
                if (pend_reg)
                begin
                    // The lower part of a block that straddles two words.
                    word_next = word_reg - AW'(1);
                    mask_next = pend_mask_reg;
                    pend_next = 1'b0;
                end
            end
            ST_BLK_ROW:
            begin
                sum_raddr = row_reg;
                if (!row_free_reg[row_reg])
                begin
                    // Every word of this row is full; no block can touch it.
                    row_next   = row_reg + RW'(1);
                    phase_next = ph_row;
                    prev_next  = '1;
                    if (last_row)
                    begin
                        res_status_next = 1'b1;
                    end
                end
            end
            ST_BLK_SUM:
            begin
                em_next   = em_rd;
                map_raddr = AW'({row_reg, 6'd0});
                word_next = AW'({row_reg, 6'd0});
            end
            ST_BLK_SCAN:
            begin
                map_raddr = word_reg + AW'(1);
                if (blk.hit)
                begin
                    mask_next      = blk.lo_mask;
                    pend_mask_next = blk.hi_mask;
                    pend_next      = |blk.hi_mask;
                    res_index_next = INDEX_W'(blk_start);
                end
                else
                begin
                    prev_next  = scan_cur;
                    phase_next = ph_word;
                    word_next  = word_reg + AW'(1);
                    if (last_word)
                    begin
                        res_status_next = 1'b1;
                    end
                    else if (cur_col == 6'(WORD_BITS - 1))
                    begin
                        row_next = row_reg + RW'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = res_index_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                map_we = 1'b0;
            end
        endcase

        sum_row_q_next = sum_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_row_q_reg <= '0;
            row_free_reg  <= '1;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_row_q_reg <= sum_row_q_next;
            row_free_reg  <= row_free_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        word_reg       <= word_next;
        row_reg        <= row_next;
        mask_reg       <= mask_next;
        pend_mask_reg  <= pend_mask_next;
        phase_reg      <= phase_next;
        prev_reg       <= prev_next;
        em_reg         <= em_next;
        res_index_reg  <= res_index_next;
        res_status_reg <= res_status_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign index     = out_index_reg;
    assign status    = out_status_reg;

    // The row flag promised a word with a free slot in the row just read.
    a_find_row_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> ((nf_rd & find_mask) != '0))
        else $error("summary row has no free word although its row flag is set");

    // The summary promised a free slot in the word being claimed.
    a_slot_word_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW_WR && mode_reg == MODE_SLOT) |-> ((rmw_old | cur_pad) != '1))
        else $error("slot allocation hit a full map word");

    // A block is only claimed over slots that are free.
    a_block_bits_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW_WR && mode_reg == MODE_SET) |-> ((rmw_old & mask_reg) == '0))
        else $error("block allocation claimed a used slot");

    // With no row holding a free slot, a slot request answers full at once.
    a_slot_full_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_ALLOC_SLOT && row_free_reg == '0)
        |=> (state_reg == ST_DONE && res_status_reg))
        else $error("full pool did not answer a slot request with status full");

endmodule

/* dv/bitmap_slot_block_allocator_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_slot_block_allocator: a directed table, then random
// allocate/free traffic. A word-level copy of the slot map predicts every result beat.
// Depends on bsba_pkg and the allocator RTL.
module bitmap_slot_block_allocator_tb;
    import bsba_pkg::*;

    // The block runs at its default size. The prediction claims a block as one whole map
    // word, which holds because a block is exactly as wide as a map word here.
    localparam int SLOTS          = DEF_SLOTS;
    localparam int MAP_WORDS      = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int FILL_AFTER     = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    // The block answers op code 3 without touching the map. It has no name in the package.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               status;
    } grant_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] idx;
        logic               known;
        logic [INDEX_W-1:0] known_index;
        logic               known_status;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] slot_index;
    logic               out_valid;
    logic               out_stall;
    logic [INDEX_W-1:0] index;
    logic               status;

    // Shadow of the slot map, one used bit per slot, and the number of used slots.
    word_t     used_map [MAP_WORDS];
    int        used_count;

    grant_t    awaited_grants[$];
    grant_t    last_grant;
    grant_t    seen_grant;
    stim_row_t directed_rows[$];
    int        held_slots[$];

    int        beats_in    = 0;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;

    bitmap_slot_block_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .slot_index (slot_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .index      (index),
        .status     (status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one beat to the shadow map and returns the result the block must give.
    // Allocation is first fit; a full pool leaves the map alone and answers index 0,
    // status 1. A free echoes its index even when the slot was already free, and op
    // code 3 answers zero on both fields.
    function automatic grant_t allocator_outcome(input logic [OP_W-1:0] o,
                                                 input logic [INDEX_W-1:0] i);
        grant_t g;
        bit     done;
        int     w;
        int     b;
        g    = '0;
        done = 1'b0;
        case (o)
            OP_ALLOC_SLOT:
            begin
                g.status = 1'b1;
                for (w = 0; w < MAP_WORDS && !done; w++)
                begin
                    if (used_map[w] != '1)
                    begin
                        for (b = 0; b < WORD_BITS && !done; b++)
                        begin
                            if (!used_map[w][b])
                            begin
                                used_map[w][b] = 1'b1;
                                used_count++;
                                g.index  = INDEX_W'(w * WORD_BITS + b);
                                g.status = 1'b0;
                                done     = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_ALLOC_BLOCK:
            begin
                g.status = 1'b1;
                for (w = 0; w < MAP_WORDS && !done; w++)
                begin
                    if (used_map[w] == '0)
                    begin
                        used_map[w] = '1;
                        used_count += WORD_BITS;
                        g.index  = INDEX_W'(w * WORD_BITS);
                        g.status = 1'b0;
                        done     = 1'b1;
                    end
                end
            end
            OP_FREE:
            begin
                if (int'(i) < SLOTS)
                begin
                    w = int'(i) / WORD_BITS;
                    b = int'(i) % WORD_BITS;
                    if (used_map[w][b])
                    begin
                        used_count--;
                    end
                    used_map[w][b] = 1'b0;
                end
                g.index = i;
            end
            default:
            begin
                g = '0;
            end
        endcase
        return g;
    endfunction

    // A slot that is in use right now, so that most frees really release something.
    function automatic logic [INDEX_W-1:0] pick_used_slot();
        int start;
        int w;
        int b;
        if (used_count == 0)
        begin
            return INDEX_W'($urandom_range(0, SLOTS - 1));
        end
        start = $urandom_range(0, MAP_WORDS - 1);
        for (int k = 0; k < MAP_WORDS; k++)
        begin
            w = (start + k) % MAP_WORDS;
            if (used_map[w] != '0)
            begin
                b = $urandom_range(0, WORD_BITS - 1);
                while (!used_map[w][b])
                begin
                    b = (b + 1) % WORD_BITS;
                end
                return INDEX_W'(w * WORD_BITS + b);
            end
        end
        return '0;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] i,
                                    input logic known, input logic [INDEX_W-1:0] k_index,
                                    input logic k_status);
        stim_row_t r;
        r.op           = o;
        r.idx          = i;
        r.known        = known;
        r.known_index  = k_index;
        r.known_status = k_status;
        directed_rows  = {directed_rows, r};
    endfunction

    // The sender works in bursts. At the start of each burst it drops valid for a gap
    // of random length; now and then a burst runs long with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 40);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
    endtask

    // Offers one beat and holds it until the block takes it. At acceptance the shadow map
    // is updated, and the beat's expected result is queued: the typed-in value where the
    // caller gives one, the prediction otherwise. The prediction is kept in last_grant.
    task automatic issue(input logic [OP_W-1:0] o, input logic [INDEX_W-1:0] i,
                         input logic known, input logic [INDEX_W-1:0] k_index,
                         input logic k_status);
        grant_t g;
        pace_sender();
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= o;
        slot_index <= i;
        do @(posedge clk); while (in_stall);
        g          = allocator_outcome(o, i);
        last_grant = g;
        if (known)
        begin
            g.index  = k_index;
            g.status = k_status;
        end
        awaited_grants = {awaited_grants, g};
        beats_in++;
    endtask

    // Frees every slot in held_slots, in random order.
    task automatic release_held();
        int j;
        while (held_slots.size() != 0)
        begin
            j = $urandom_range(0, held_slots.size() - 1);
            issue(OP_FREE, INDEX_W'(held_slots[j]), 1'b0, '0, 1'b0);
            held_slots.delete(j);
        end
    endtask

    // Random traffic: mostly allocations and frees of slots in use, with some frees of
    // random slots and some unused op codes as noise. The index field is random on every
    // beat but a free of a slot in use, so the block is seen to ignore it where it should.
    task automatic mixed_traffic();
        int pick;
        int len;
        len = $urandom_range(30, 120);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                issue(OP_ALLOC_SLOT, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
            end
            else if (pick < 52)
            begin
                issue(OP_ALLOC_BLOCK, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
            end
            else if (pick < 85)
            begin
                issue(OP_FREE, pick_used_slot(), 1'b0, '0, 1'b0);
            end
            else if (pick < 95)
            begin
                issue(OP_FREE, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
            end
            else
            begin
                issue(OP_UNUSED, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
            end
        end
    endtask

    // Takes a handful of slots and gives them back in random order: the next allocations
    // must land in the same holes again, lowest first.
    task automatic churn_slots();
        int k;
        k = $urandom_range(1, 16);
        repeat (k)
        begin
            issue(OP_ALLOC_SLOT, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
            if (last_grant.status == 1'b0)
            begin
                held_slots = {held_slots, int'(last_grant.index)};
            end
        end
        release_held();
    endtask

    // Fills the pool to the top: blocks while an empty word is left, then single slots,
    // until each kind of allocation reports the pool full. Then single holes and one whole
    // word are opened again at random places, and the allocator must find each of them.
    task automatic fill_pool();
        int w;
        logic [INDEX_W-1:0] hole;
        do issue(OP_ALLOC_BLOCK, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
        while (last_grant.status == 1'b0);
        do issue(OP_ALLOC_SLOT, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
        while (last_grant.status == 1'b0);
        issue(OP_ALLOC_SLOT, '1, 1'b1, '0, 1'b1);
        issue(OP_ALLOC_BLOCK, '1, 1'b1, '0, 1'b1);
        repeat (3)
        begin
            hole = INDEX_W'($urandom_range(0, SLOTS - 1));
            issue(OP_FREE, hole, 1'b1, hole, 1'b0);
            issue(OP_ALLOC_SLOT, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
        end
        w = $urandom_range(0, MAP_WORDS - 1);
        for (int b = 0; b < WORD_BITS; b++)
        begin
            held_slots = {held_slots, w * WORD_BITS + b};
        end
        release_held();
        issue(OP_ALLOC_BLOCK, INDEX_W'($urandom()), 1'b0, '0, 1'b0);
        issue(OP_ALLOC_BLOCK, INDEX_W'($urandom()), 1'b1, '0, 1'b1);
    endtask

    // Sender: reset, the directed table, then random traffic, then the end of the run.
    initial
    begin : sender
        bit filled;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = OP_ALLOC_SLOT;
        slot_index = '0;
        filled     = 1'b0;
        used_count = 0;
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            used_map[w] = '0;
        end

        // Directed table, starting from an empty pool. Rows that can be read off at a
        // glance carry their result; the rest are left to the prediction.
        add_row(OP_ALLOC_SLOT,  15'd0,     1'b1, 15'd0,     1'b0);
        add_row(OP_ALLOC_SLOT,  15'd32767, 1'b1, 15'd1,     1'b0);
        add_row(OP_ALLOC_BLOCK, 15'd32767, 1'b1, 15'd64,    1'b0);
        add_row(OP_ALLOC_BLOCK, 15'd0,     1'b1, 15'd128,   1'b0);
        add_row(OP_FREE,        15'd0,     1'b1, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd0,     1'b1, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd32767, 1'b1, 15'd32767, 1'b0);
        add_row(OP_UNUSED,      15'd32767, 1'b1, 15'd0,     1'b0);
        add_row(OP_UNUSED,      15'd0,     1'b1, 15'd0,     1'b0);
        add_row(OP_ALLOC_SLOT,  15'd21845, 1'b0, 15'd0,     1'b0);
        add_row(OP_ALLOC_SLOT,  15'd10922, 1'b0, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd64,    1'b1, 15'd64,    1'b0);
        add_row(OP_ALLOC_SLOT,  15'd0,     1'b0, 15'd0,     1'b0);
        add_row(OP_ALLOC_BLOCK, 15'd0,     1'b0, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd21845, 1'b1, 15'd21845, 1'b0);
        add_row(OP_FREE,        15'd10922, 1'b1, 15'd10922, 1'b0);
        add_row(OP_ALLOC_SLOT,  15'd0,     1'b0, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd127,   1'b1, 15'd127,   1'b0);
        add_row(OP_ALLOC_BLOCK, 15'd0,     1'b0, 15'd0,     1'b0);
        add_row(OP_ALLOC_SLOT,  15'd0,     1'b0, 15'd0,     1'b0);
        add_row(OP_FREE,        15'd1,     1'b1, 15'd1,     1'b0);
        add_row(OP_ALLOC_SLOT,  15'd0,     1'b0, 15'd0,     1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            issue(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].known,
                  directed_rows[r].known_index, directed_rows[r].known_status);
        end

        // The pool is filled once, partway through, so that the later traffic runs
        // against a nearly full map.
        while (beats_in < directed_rows.size() + RANDOM_ITEMS)
        begin
            if (!filled && beats_in >= directed_rows.size() + FILL_AFTER)
            begin
                fill_pool();
                filled = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                churn_slots();
            end
            else
            begin
                mixed_traffic();
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (awaited_grants.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: out_stall follows segments of random length, each with its own pattern:
    // never stalled, stalled now and then, stalled most of the time, or a fixed rhythm.
    // Twice in the run it holds off for a long stretch while the sender keeps offering
    // beats, so that the output register fills and the block stalls its input side.
    initial
    begin : receiver
        int holds_done;
        int mode;
        int seg_len;
        int tick;
        holds_done = 0;
        tick       = 0;
        out_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ((holds_done == 0 && beats_in >= 120) || (holds_done == 1 && beats_in >= 900))
            begin
                holds_done++;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(10, 150);
            repeat (seg_len)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // Every result beat is checked against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_grants.size() == 0)
            begin
                $error("result beat with nothing expected: index %0d status %0d",
                       index, status);
                mismatches++;
            end
            else
            begin
                seen_grant = awaited_grants.pop_front();
                if (index !== seen_grant.index)
                begin
                    $error("index: expected %0d, got %0d", seen_grant.index, index);
                    mismatches++;
                end
                if (status !== seen_grant.status)
                begin
                    $error("status: expected %0d, got %0d", seen_grant.status, status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
